/* src/centered_fir_shift_normalize_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the centered FIR block checker
// Wraps a concurrent property with clocking, an optional reset disable and
// an error report.
// ---------------------------------------------------------------------------
`ifndef CENTERED_FIR_SHIFT_NORMALIZE_TOP_ASSERT_SVH
`define CENTERED_FIR_SHIFT_NORMALIZE_TOP_ASSERT_SVH

// Check a property on every rising edge while reset is released.
`define CFSN_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cfsn assertion failed");

// Check a property on every rising edge, reset included.
`define CFSN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cfsn assertion failed");

`endif

/* src/cfsn_pkg.sv */
// ---------------------------------------------------------------------------
// cfsn_pkg
// Types, register codes and the normalize/saturate function shared by the
// centered FIR block.
// ---------------------------------------------------------------------------
`default_nettype none

package cfsn_pkg;

    localparam int WIN_TAPS = 7;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int SUM_W    = 19;
    localparam int NORM_W   = 21;

    localparam logic [1:0] HALF_W = 2'd3;

    // register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_COEFF0 = 3'd1;

    // filter modes
    localparam logic MODE_5TAP = 1'b0;
    localparam logic MODE_7TAP = 1'b1;

    typedef logic signed [7:0]  t_sample;
    typedef logic signed [15:0] t_prod;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef t_sample [WIN_TAPS-1:0] t_win;

    typedef struct packed {
        logic last;
        logic mode;
    } t_evt;

    // Divide by about 12 (five taps) or 60 (seven taps), correct negative
    // sums, saturate to eight bits.
    function automatic t_sample fn_norm(input t_sum sum, input logic mode);
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] r;
        x = signed'({{(NORM_W-SUM_W){sum[SUM_W-1]}}, sum});
        if (mode == MODE_5TAP) begin
            r = (x >>> 4) + (x >>> 6) + (x >>> 8) + (x >>> 10);
            if (sum[SUM_W-1]) begin
                r = r + NORM_W'(4);
            end
        end else begin
            r = (x >>> 6) + (x >>> 10);
            if (sum[SUM_W-1]) begin
                r = r + NORM_W'(2);
            end
        end
        if (r > NORM_W'(127)) begin
            r = NORM_W'(127);
        end else if (r < -NORM_W'(128)) begin
            r = -NORM_W'(128);
        end
        return r[7:0];
    endfunction

endpackage

`default_nettype wire

/* src/centered_fir_shift_normalize_top.sv */
// ---------------------------------------------------------------------------
// centered_fir_shift_normalize_top
// Centered FIR filter (7-sample window, five or seven taps) with shift
// normalization and saturation, one filtered sample per input sample, configured over APB.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  ---------------------------------
//  sample    in         i_valid / o_ready     i_sample_in, i_last_sample
//  result    out        o_valid / i_ready     o_filtered_value, o_last_result
//  config    in         psel/penable/pready   paddr, pwrite, pwdata, prdata
//
//  One sample transaction per cycle while o_ready is high; a result passes
//  the product and sum stages into the output register and can be taken at
//  the next edge, when not stalled.
//  A sample marked last flushes up to three pending results (one step each,
//  the window slider being the single producer), with o_ready low.
//  Reset is synchronous, active low, and clears the window, warm-up count,
//  flush state, registers and all stage valid bits.
//  A stall on the result side backs up stage by stage; bubbles still fill.
//
`default_nettype none

module centered_fir_shift_normalize_top import cfsn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // APB configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    // sample channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic signed [7:0] i_sample_in,
    input  wire logic              i_last_sample,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [7:0]      o_filtered_value,
    output logic                   o_last_result
);

    // configuration registers
    logic        r_mode;
    t_win        r_coeff;

    // window slider state
    t_win        r_win;
    logic [1:0]  r_warm;   // samples seen, saturating at three
    logic [1:0]  r_fcnt;   // flush results still to produce
    logic [1:0]  r_lead;   // zero shifts before the next flush result

    t_win        n_win;
    logic [1:0]  n_warm, n_fcnt, n_lead;

    logic        evt_ready;
    logic        evt_valid;
    t_evt        evt;
    t_win        evt_win;
    t_win        win_in;
    t_win        win_fl;
    logic        acc;
    logic        fstep;
    logic [2:0]  reg_idx;
    logic [3:0]  src_idx;

    // -----------------------------------------------------------------------
    // APB: write on the access phase, read back any register
    // -----------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_5TAP;
            r_coeff <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_MODE: r_mode <= pwdata[0];
                default:  r_coeff[reg_idx - REG_COEFF0] <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE: prdata = {{(DATA_W-1){1'b0}}, r_mode};
            default:  prdata = {{(DATA_W-8){r_coeff[reg_idx - REG_COEFF0][7]}},
                                r_coeff[reg_idx - REG_COEFF0]};
        endcase
    end

    // -----------------------------------------------------------------------
    // Window slider: take samples, then drain pending results with zeros
    // -----------------------------------------------------------------------

    // hold off new samples while flushing or while the pipe is full
    assign o_ready = (r_fcnt == 2'd0) && evt_ready;
    assign acc     = i_valid && o_ready;
    assign fstep   = (r_fcnt != 2'd0) && evt_ready;

    always_comb begin
        // advance by one with the incoming sample at the newest position
        for (int k = 0; k < WIN_TAPS - 1; k++) begin
            win_in[k] = r_win[k+1];
        end
        win_in[WIN_TAPS-1] = i_sample_in;

        // advance by the lead count with zeros shifted in
        for (int k = 0; k < WIN_TAPS; k++) begin
            src_idx = 4'(k) + {2'b00, r_lead};
            if (src_idx < 4'(WIN_TAPS)) begin
                win_fl[k] = r_win[src_idx[2:0]];
            end else begin
                win_fl[k] = '0;
            end
        end
    end

    always_comb begin
        n_win     = r_win;
        n_warm    = r_warm;
        n_fcnt    = r_fcnt;
        n_lead    = r_lead;
        evt_valid = 1'b0;
        evt_win   = win_in;
        evt.last  = 1'b0;
        evt.mode  = r_mode;

        if (acc) begin
            n_win = win_in;
            if (r_warm == HALF_W) begin
                // warm-up done: result centered three samples back
                evt_valid = 1'b1;
            end else begin
                n_warm = r_warm + 2'd1;
            end
            if (i_last_sample) begin
                n_warm = 2'd0;
                if (r_warm == HALF_W) begin
                    n_fcnt = HALF_W;
                    n_lead = 2'd1;
                end else begin
                    // short sequence: jump straight to the first centered view
                    n_fcnt = r_warm + 2'd1;
                    n_lead = HALF_W - r_warm;
                end
            end
        end else if (fstep) begin
            evt_valid = 1'b1;
            evt_win   = win_fl;
            evt.last  = (r_fcnt == 2'd1);
            n_fcnt    = r_fcnt - 2'd1;
            n_lead    = 2'd1;
            // drop the window once the sequence has drained
            n_win     = (r_fcnt == 2'd1) ? '0 : win_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_warm <= 2'd0;
            r_fcnt <= 2'd0;
            r_lead <= 2'd0;
        end else begin
            r_win  <= n_win;
            r_warm <= n_warm;
            r_fcnt <= n_fcnt;
            r_lead <= n_lead;
        end
    end

    // -----------------------------------------------------------------------
    // Multiply, sum, normalize and saturate
    // -----------------------------------------------------------------------
    cfsn_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .i_evt       (evt),
        .i_win       (evt_win),
        .i_coeff     (r_coeff),
        .o_evt_ready (evt_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_filtered_value),
        .o_last      (o_last_result)
    );

endmodule

`default_nettype wire

/* src/cfsn_pipe.sv */
// ---------------------------------------------------------------------------
// cfsn_pipe
// Multiply, sum and normalize pipeline: product stage, sum stage and output
// register, each stage moving on its own when the next one has room.
// ---------------------------------------------------------------------------
`default_nettype none

module cfsn_pipe import cfsn_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_evt_valid,
    input  wire t_evt    i_evt,
    input  wire t_win    i_win,
    input  wire t_win    i_coeff,
    output logic         o_evt_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_sample      o_value,
    output logic         o_last
);

    logic                r_p_valid;
    t_evt                r_p_evt;
    t_prod [WIN_TAPS-1:0] r_prod;
    logic                r_s_valid;
    t_evt                r_s_evt;
    t_sum                r_sum;
    logic                r_o_valid;
    t_sample             r_o_value;
    logic                r_o_last;

    logic                o_en, s_en, p_en;
    t_prod [WIN_TAPS-1:0] n_prod;
    t_sum                n_sum;

    assign o_en        = !r_o_valid || i_ready;
    assign s_en        = !r_s_valid || o_en;
    assign p_en        = !r_p_valid || s_en;
    assign o_evt_ready = p_en;

    always_comb begin
        for (int k = 0; k < WIN_TAPS; k++) begin
            n_prod[k] = 16'(i_win[k]) * 16'(i_coeff[k]);
        end
        // outer taps drop out in five-tap mode
        if (i_evt.mode == MODE_5TAP) begin
            n_prod[0]          = '0;
            n_prod[WIN_TAPS-1] = '0;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < WIN_TAPS; k++) begin
            n_sum = n_sum + SUM_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_en) begin
                r_p_valid <= i_evt_valid;
            end
            if (s_en) begin
                r_s_valid <= r_p_valid;
            end
            if (o_en) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_en && i_evt_valid) begin
            r_prod  <= n_prod;
            r_p_evt <= i_evt;
        end
        if (s_en && r_p_valid) begin
            r_sum   <= n_sum;
            r_s_evt <= r_p_evt;
        end
        if (o_en && r_s_valid) begin
            r_o_value <= fn_norm(r_sum, r_s_evt.mode);
            r_o_last  <= r_s_evt.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_value = r_o_value;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

/* src/cfsn_checker.sv */
// ---------------------------------------------------------------------------
// cfsn_checker
// Port-level checks for the centered FIR block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "centered_fir_shift_normalize_top_assert.svh"

module cfsn_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       i_last_sample,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_filtered_value,
    input wire logic       o_last_result
);

    property p_out_hold;
        o_valid && !i_ready |=>
            o_valid && $stable(o_filtered_value) && $stable(o_last_result);
    endproperty

    property p_flush_stall;
        i_valid && o_ready && i_last_sample |=> !o_ready;
    endproperty

    // a stalled result holds
    `CFSN_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold)

    // a result only goes away after it was taken
    `CFSN_ASSERT(a_out_drop, i_clk, i_rst_n, $fell(o_valid) && $past(i_rst_n) |-> $past(i_ready))

    // a last sample always starts a flush, so the next sample waits
    `CFSN_ASSERT(a_flush_stall, i_clk, i_rst_n, p_flush_stall)

    // reset empties the output register
    `CFSN_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind centered_fir_shift_normalize_top cfsn_checker u_cfsn_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_last_sample    (i_last_sample),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_filtered_value (o_filtered_value),
    .o_last_result    (o_last_result)
);

`default_nettype wire
